@@ rtl/hip_pkg.sv @@
package hip_pkg;

  localparam int COORD_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int ROOT_W = 31;          // square roots carry 30 fraction bits
  localparam int RAD_W  = 2 * ROOT_W;  // radicand width
  localparam int CX_W   = 34;          // CORDIC x/y datapath
  localparam int ANG_W  = 32;          // CORDIC angle, 30 fraction bits

  localparam int LON_W   = 16;
  localparam int LAT_W   = 15;
  localparam int LON_MAX = 25736;
  localparam int LAT_MAX = 12868;
  localparam int OUT_SHIFT = 17;       // 30 -> 13 fraction bits

  // floor(atan(2^-i) * 2^30)
  function automatic logic [ANG_W-1:0] atan_entry(input int i);
    logic [ANG_W-1:0] v;
    case (i)
      0:  v = 32'd843314856;
      1:  v = 32'd497837829;
      2:  v = 32'd263043836;
      3:  v = 32'd133525158;
      4:  v = 32'd67021686;
      5:  v = 32'd33543515;
      6:  v = 32'd16775850;
      7:  v = 32'd8388437;
      8:  v = 32'd4194282;
      9:  v = 32'd2097149;
      10: v = 32'd1048575;
      11: v = 32'd524287;
      12: v = 32'd262143;
      13: v = 32'd131071;
      14: v = 32'd65535;
      15: v = 32'd32767;
      16: v = 32'd16383;
      17: v = 32'd8191;
      18: v = 32'd4095;
      19: v = 32'd2047;
      20: v = 32'd1023;
      21: v = 32'd511;
      22: v = 32'd255;
      23: v = 32'd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/hip_if.sv @@
interface hip_in_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;

  modport source (output valid, x_coord, y_coord, input ready);
  modport sink   (input valid, x_coord, y_coord, output ready);
endinterface

interface hip_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] longitude;
  logic signed [14:0] latitude;
  logic               point_valid;

  modport source (output valid, longitude, latitude, point_valid, input ready);
  modport sink   (input valid, longitude, latitude, point_valid, output ready);
endinterface

@@ rtl/inverse_hammer_projection.sv @@
// Inverse Hammer projection: one (x_coord, y_coord) point per clock in, one
// (longitude, latitude, point_valid) result per clock out while the sink is ready, fully pipelined.
// The pipe holds 69 + CORDIC_STAGES register stages (85 by default): two
// stages for the squared radius, two 31-stage bit-per-stage square roots,
// three multiply stages, the CORDIC stages, a rounding stage and the output
// register.
// A two-entry output buffer lets the pipe keep taking points while a result
// waits; throughput is one transfer per cycle whenever the sink is ready.
// Points outside the ellipse, or with x = 0 on its rim, give point_valid = 0
// and zero angles.
module inverse_hammer_projection #(
  parameter int CORDIC_STAGES = hip_pkg::CORDIC_STAGES_DEF,
  parameter int COORD_WIDTH   = hip_pkg::COORD_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  hip_in_if.sink     coord,
  hip_out_if.source  angle
);
  import hip_pkg::*;

  localparam int FB  = COORD_WIDTH - 1;
  localparam int CW  = COORD_WIDTH;
  localparam int S_W = 2 * FB + 2;
  localparam logic [S_W-1:0] ONE     = S_W'(1) << (2 * FB);
  localparam logic [S_W-1:0] TWO_ONE = S_W'(1) << (2 * FB + 1);
  localparam int RAD_SH = 60 - 2 * FB;
  localparam int D_SHR  = (2 * FB >= 30) ? 2 * FB - 30 : 0;
  localparam int D_SHL  = (2 * FB >= 30) ? 0 : 30 - 2 * FB;
  localparam int P_W    = ROOT_W + CW;
  localparam logic [31:0] T_MAX = 32'd1 << 30;
  localparam int RW_W   = 35;

  logic adv;

  // stage 1: magnitudes and squares
  logic          v1, sx1, sy1, xz1;
  logic [CW-1:0] ax1, ay1;
  logic [2*CW-1:0] pxx1, pyy1;
  logic [CW-1:0] ax_c, ay_c;

  assign ax_c = coord.x_coord[CW-1] ? (~coord.x_coord + 1'b1) : coord.x_coord;
  assign ay_c = coord.y_coord[CW-1] ? (~coord.y_coord + 1'b1) : coord.y_coord;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= coord.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx1  <= coord.x_coord[CW-1];
      sy1  <= coord.y_coord[CW-1];
      xz1  <= coord.x_coord == '0;
      ax1  <= ax_c;
      ay1  <= ay_c;
      pxx1 <= ax_c * ax_c;
      pyy1 <= ay_c * ay_c;
    end
  end

  // stage 2: radius test, sqrt radicand, denominator
  logic          v2, sx2, sy2, ok2;
  logic [CW-1:0] ax2, ay2;
  logic [RAD_W-1:0] rad1;
  logic [30:0]   den2;
  logic [S_W-1:0] s_c, d_c;

  assign s_c = pxx1 + pyy1;
  assign d_c = ONE - s_c;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx2  <= sx1;
      sy2  <= sy1;
      ax2  <= ax1;
      ay2  <= ay1;
      ok2  <= !((s_c > ONE) || (xz1 && s_c == ONE));
      rad1 <= RAD_W'(TWO_ONE - s_c) << RAD_SH;
      den2 <= 31'((RAD_W'(d_c) >> D_SHR) << D_SHL);
    end
  end

  // w = sqrt(2 - s)
  localparam int A_W = 3 + 2 * CW + 31;
  logic [ROOT_W-1:0] w;
  logic          va;
  logic [A_W-1:0] da;

  hip_sqrt #(.OUT_W(ROOT_W)) u_sqrt_w (
    .clk (clk), .en (adv), .rad (rad1), .root (w)
  );

  hip_delay #(.W(A_W), .D(ROOT_W)) u_dly_a (
    .clk (clk), .rst (rst), .en (adv),
    .vin (v2), .din ({ok2, sx2, sy2, ax2, ay2, den2}),
    .vout (va), .dout (da)
  );

  logic          ok_a, sx_a, sy_a;
  logic [CW-1:0] ax_a, ay_a;
  logic [30:0]   den_a;
  assign {ok_a, sx_a, sy_a, ax_a, ay_a, den_a} = da;

  // m1: products
  logic        vm1, okm1, sxm1, sym1;
  logic [31:0] magm1, trm1;
  logic [30:0] denm1;
  logic [P_W-1:0] pm_c, pt_c;

  assign pm_c = w * ax_a;
  assign pt_c = w * ay_a;

  always_ff @(posedge clk) begin
    if (rst) vm1 <= 1'b0;
    else if (adv) vm1 <= va;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      okm1  <= ok_a;
      sxm1  <= sx_a;
      sym1  <= sy_a;
      denm1 <= den_a;
      magm1 <= 32'(pm_c >> FB);
      trm1  <= 32'(pt_c >> FB);
    end
  end

  // m2: signs and clamp
  logic               vm2, okm2;
  logic signed [32:0] numm2;
  logic signed [31:0] tsm2;
  logic [30:0]        tm2, denm2, t_c;

  assign t_c = (trm1 > T_MAX) ? 31'(T_MAX) : trm1[30:0];

  always_ff @(posedge clk) begin
    if (rst) vm2 <= 1'b0;
    else if (adv) vm2 <= vm1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      okm2  <= okm1;
      denm2 <= denm1;
      tm2   <= t_c;
      numm2 <= sxm1 ? -$signed({1'b0, magm1}) : $signed({1'b0, magm1});
      tsm2  <= sym1 ? -$signed({1'b0, t_c}) : $signed({1'b0, t_c});
    end
  end

  // m3: 1 - t*t
  logic               vm3, okm3;
  logic signed [32:0] numm3;
  logic signed [31:0] tsm3;
  logic [30:0]        denm3;
  logic [RAD_W-1:0]   rad2;

  always_ff @(posedge clk) begin
    if (rst) vm3 <= 1'b0;
    else if (adv) vm3 <= vm2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      okm3  <= okm2;
      numm3 <= numm2;
      tsm3  <= tsm2;
      denm3 <= denm2;
      rad2  <= (RAD_W'(1) << 60) - (RAD_W'(tm2) * RAD_W'(tm2));
    end
  end

  // c = sqrt(1 - t*t)
  localparam int B_W = 1 + 33 + 32 + 31;
  logic [ROOT_W-1:0] c;
  logic              vb;
  logic [B_W-1:0]    db;

  hip_sqrt #(.OUT_W(ROOT_W)) u_sqrt_c (
    .clk (clk), .en (adv), .rad (rad2), .root (c)
  );

  hip_delay #(.W(B_W), .D(ROOT_W)) u_dly_b (
    .clk (clk), .rst (rst), .en (adv),
    .vin (vm3), .din ({okm3, numm3, tsm3, denm3}),
    .vout (vb), .dout (db)
  );

  logic               ok_b;
  logic signed [32:0] num_b;
  logic signed [31:0] ts_b;
  logic [30:0]        den_b;
  assign {ok_b, num_b, ts_b, den_b} = db;

  // both angles
  logic signed [ANG_W-1:0] a_lon, a_lat;
  logic       vc;
  logic [0:0] okc;

  hip_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lon (
    .clk (clk), .en (adv),
    .cx  ($signed(CX_W'(den_b))), .cy (CX_W'(num_b)),
    .ang (a_lon)
  );

  hip_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lat (
    .clk (clk), .en (adv),
    .cx  ($signed(CX_W'(c))), .cy (CX_W'(ts_b)),
    .ang (a_lat)
  );

  hip_delay #(.W(1), .D(CORDIC_STAGES)) u_dly_c (
    .clk (clk), .rst (rst), .en (adv),
    .vin (vb), .din (ok_b),
    .vout (vc), .dout (okc)
  );

  // rounding and saturation
  logic signed [RW_W-1:0] lon_r, lat_r;
  logic signed [LON_W-1:0] lon_c;
  logic signed [LAT_W-1:0] lat_c;

  assign lon_r = ((RW_W'(a_lon) <<< 1) + (RW_W'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
  assign lat_r = (RW_W'(a_lat) + (RW_W'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;

  always_comb begin
    if (lon_r > RW_W'(LON_MAX))       lon_c = LON_W'(LON_MAX);
    else if (lon_r < -RW_W'(LON_MAX)) lon_c = -LON_W'(LON_MAX);
    else                              lon_c = lon_r[LON_W-1:0];
    if (lat_r > RW_W'(LAT_MAX))       lat_c = LAT_W'(LAT_MAX);
    else if (lat_r < -RW_W'(LAT_MAX)) lat_c = -LAT_W'(LAT_MAX);
    else                              lat_c = lat_r[LAT_W-1:0];
  end

  logic                    rv, r_pv;
  logic signed [LON_W-1:0] r_lon;
  logic signed [LAT_W-1:0] r_lat;

  always_ff @(posedge clk) begin
    if (rst) rv <= 1'b0;
    else if (adv) rv <= vc;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_pv  <= okc[0];
      r_lon <= okc[0] ? lon_c : '0;
      r_lat <= okc[0] ? lat_c : '0;
    end
  end

  // output register plus skid entry
  logic                    o_v, o_pv, sk_v, sk_pv;
  logic signed [LON_W-1:0] o_lon, sk_lon;
  logic signed [LAT_W-1:0] o_lat, sk_lat;
  logic                    taking;

  assign taking = o_v && angle.ready;
  assign adv    = !sk_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v  <= 1'b0;
      sk_v <= 1'b0;
    end else if (!o_v || taking) begin
      if (sk_v) begin
        o_v  <= 1'b1;
        sk_v <= 1'b0;
      end else begin
        o_v <= rv;
      end
    end else if (!sk_v && rv) begin
      sk_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!o_v || taking) begin
      if (sk_v) begin
        o_pv  <= sk_pv;
        o_lon <= sk_lon;
        o_lat <= sk_lat;
      end else begin
        o_pv  <= r_pv;
        o_lon <= r_lon;
        o_lat <= r_lat;
      end
    end else if (!sk_v) begin
      sk_pv  <= r_pv;
      sk_lon <= r_lon;
      sk_lat <= r_lat;
    end
  end

  assign coord.ready       = adv;
  assign angle.valid       = o_v;
  assign angle.point_valid = o_pv;
  assign angle.longitude   = o_lon;
  assign angle.latitude    = o_lat;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst) sk_v |-> o_v)
    else $error("skid entry held while output register empty");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (o_v && !o_pv) |-> (o_lon == '0 && o_lat == '0))
    else $error("rejected point carries nonzero angles");
  a_lat_range: assert property (@(posedge clk) disable iff (rst)
    o_v |-> (o_lat <= LAT_W'(LAT_MAX) && o_lat >= -LAT_W'(LAT_MAX)))
    else $error("latitude out of range");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (o_v && !angle.ready) |=> (o_v && $stable(o_lon) && $stable(o_lat)))
    else $error("output changed while stalled");
`endif

endmodule

@@ rtl/hip_delay.sv @@
module hip_delay #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         vin,
  input  logic [W-1:0] din,
  output logic         vout,
  output logic [W-1:0] dout
);

  logic [D-1:0] v;
  logic [W-1:0] d [D];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v[0] <= vin;
      for (int i = 1; i < D; i++) begin
        v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d[0] <= din;
      for (int i = 1; i < D; i++) begin
        d[i] <= d[i-1];
      end
    end
  end

  assign vout = v[D-1];
  assign dout = d[D-1];

endmodule

@@ rtl/hip_sqrt.sv @@
// Pipelined floor square root, one root bit per stage.
module hip_sqrt #(
  parameter int OUT_W = 31
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [2*OUT_W-1:0]   rad,
  output logic [OUT_W-1:0]     root
);

  localparam int RW = 2 * OUT_W + 1;

  logic [RW-1:0]    rem_q [OUT_W];
  logic [OUT_W-1:0] q_q   [OUT_W];

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    localparam int B = OUT_W - 1 - k;
    logic [RW-1:0]    rem_in;
    logic [OUT_W-1:0] q_in;
    logic [RW-1:0]    trial;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_in = RW'(rad);
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign q_in   = q_q[k-1];
    end

    // (q + 2^B)^2 - q^2
    assign trial = (RW'(q_in) << (B + 1)) | (RW'(1) << (2 * B));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        q_q[k] <= take ? (q_in | (OUT_W'(1) << B)) : q_in;
      end
    end

    if (k < OUT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= take ? (rem_in - trial) : rem_in;
        end
      end
    end else begin : g_norem
      assign rem_q[k] = '0;
    end
  end

  assign root = q_q[OUT_W-1];

endmodule

@@ rtl/hip_cordic.sv @@
// Vectoring CORDIC, one stage per micro-rotation, no gain correction.
module hip_cordic #(
  parameter int STAGES = 16
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [hip_pkg::CX_W-1:0]  cx,
  input  logic signed [hip_pkg::CX_W-1:0]  cy,
  output logic signed [hip_pkg::ANG_W-1:0] ang
);
  import hip_pkg::*;

  logic signed [CX_W-1:0]  x_q [STAGES];
  logic signed [CX_W-1:0]  y_q [STAGES];
  logic signed [ANG_W-1:0] a_q [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [CX_W-1:0]  x_in, y_in, dx, dy;
    logic signed [ANG_W-1:0] a_in, step;

    if (i == 0) begin : g_first
      assign x_in = cx;
      assign y_in = cy;
      assign a_in = '0;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign a_in = a_q[i-1];
    end

    assign dx   = y_in >>> i;
    assign dy   = x_in >>> i;
    assign step = $signed(atan_entry(i));

    always_ff @(posedge clk) begin
      if (en) begin
        a_q[i] <= y_in[CX_W-1] ? (a_in - step) : (a_in + step);
      end
    end

    if (i < STAGES - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (en) begin
          if (!y_in[CX_W-1]) begin
            x_q[i] <= x_in + dx;
            y_q[i] <= y_in - dy;
          end else begin
            x_q[i] <= x_in - dx;
            y_q[i] <= y_in + dy;
          end
        end
      end
    end else begin : g_noxy
      assign x_q[i] = '0;
      assign y_q[i] = '0;
    end
  end

  assign ang = a_q[STAGES-1];

endmodule

@@ bench/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hip_pkg::*;

  localparam int STAGES    = CORDIC_STAGES_DEF;
  localparam int CW        = COORD_WIDTH_DEF;
  localparam int LATENCY   = 69 + STAGES;
  localparam int MAX_CYCLE = 400000;

  typedef struct {
    logic signed [LON_W-1:0] lon;
    logic signed [LAT_W-1:0] lat;
    logic                    pv;
  } angles_t;

  class angle_scoreboard;
    angles_t pending_q[$];
    int      errors = 0;

    static function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // vectoring rotation toward y = 0, no gain fix, y = 0 takes the positive branch
    static function longint vector_angle(longint vx, longint vy);
      longint acc, dx, dy;
      int n;
      acc = 0;
      n = (STAGES > 24) ? 24 : STAGES;
      for (int i = 0; i < n; i++) begin
        dx = vy >>> i;
        dy = vx >>> i;
        if (vy >= 0) begin
          vx = vx + dx;
          vy = vy - dy;
          acc = acc + longint'(atan_entry(i));
        end else begin
          vx = vx - dx;
          vy = vy + dy;
          acc = acc - longint'(atan_entry(i));
        end
      end
      return acc;
    endfunction

    static function longint round_clip(longint v, longint lim);
      longint r;
      r = (v + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
    endfunction

    static function angles_t project(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
      angles_t e;
      longint unsigned ax, ay, s, one, d, den, w, mag, t, c;
      longint sx, sy, num, ts;
      sx = x;
      sy = y;
      ax = (sx < 0) ? -sx : sx;
      ay = (sy < 0) ? -sy : sy;
      s = ax * ax + ay * ay;
      one = 64'd1 << (2 * (CW - 1));
      e.lon = '0;
      e.lat = '0;
      e.pv = 1'b0;
      if (s > one) return e;
      d = one - s;
      if (sx == 0 && d == 0) return e;   // zero over zero
      w = floor_sqrt((2 * one - s) << (60 - 2 * (CW - 1)));
      mag = (w * ax) >> (CW - 1);
      num = (sx < 0) ? -longint'(mag) : longint'(mag);
      if (2 * (CW - 1) >= 30) den = d >> (2 * (CW - 1) - 30);
      else den = d << (30 - 2 * (CW - 1));
      e.lon = LON_W'(round_clip(2 * vector_angle(longint'(den), num), LON_MAX));
      t = (w * ay) >> (CW - 1);
      if (t > (64'd1 << 30)) t = 64'd1 << 30;
      c = floor_sqrt((64'd1 << 60) - t * t);
      ts = (sy < 0) ? -longint'(t) : longint'(t);
      e.lat = LAT_W'(round_clip(vector_angle(longint'(c), ts), LAT_MAX));
      e.pv = 1'b1;
      return e;
    endfunction

    function void note(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
      pending_q.push_back(project(x, y));
    endfunction

    function void check(logic signed [LON_W-1:0] lon, logic signed [LAT_W-1:0] lat,
                        logic pv);
      angles_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result lon=%0d lat=%0d valid=%0b", $time, lon, lat,
                 pv);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (lon !== e.lon) begin
        $display("%0t: longitude expected %0d actual %0d", $time, e.lon, lon);
        errors++;
      end
      if (lat !== e.lat) begin
        $display("%0t: latitude expected %0d actual %0d", $time, e.lat, lat);
        errors++;
      end
      if (pv !== e.pv) begin
        $display("%0t: point_valid expected %0b actual %0b", $time, e.pv, pv);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle = 0;
  int   idle_in = 27;
  int   idle_out = 74;

  angle_scoreboard sb = new();

  hip_in_if #(.COORD_WIDTH(CW)) coord_ch();
  hip_out_if angle_ch();

  inverse_hammer_projection #(.CORDIC_STAGES(STAGES), .COORD_WIDTH(CW)) uut (
    .clk(clk),
    .rst(rst),
    .coord(coord_ch),
    .angle(angle_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("[inverse_hammer_projection] ERROR");
      $finish;
    end
  end

  initial begin
    coord_ch.valid = 1'b0;
    coord_ch.x_coord = '0;
    coord_ch.y_coord = '0;
    angle_ch.ready = 1'b0;
  end

  // result side: sample at rising edge, change ready at falling edge
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && angle_ch.valid && angle_ch.ready)
        sb.check(angle_ch.longitude, angle_ch.latitude, angle_ch.point_valid);
      @(negedge clk);
      angle_ch.ready <= (rst == 1'b0) && ($urandom_range(0, 99) >= idle_out);
    end
  end

  task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < idle_in) coord_ch.valid <= 1'b0;
      else break;
    end
    coord_ch.valid <= 1'b1;
    coord_ch.x_coord <= x;
    coord_ch.y_coord <= y;
    do @(posedge clk); while (!coord_ch.ready);
    sb.note(x, y);
  endtask

  // mostly points inside the ellipse, some anywhere in the square
  task automatic send_random(int count);
    logic signed [CW-1:0] x, y;
    longint sq;
    for (int k = 0; k < count; k++) begin
      x = CW'($urandom);
      y = CW'($urandom);
      if ($urandom_range(0, 9) < 7) begin
        do begin
          x = CW'($urandom);
          y = CW'($urandom);
          if ($urandom_range(0, 3) == 0) x = x >>> $urandom_range(1, 12);
          sq = longint'(x) * x + longint'(y) * y;
        end while (sq > (64'sd1 << 30));
      end
      send_point(x, y);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_point(16'sd0, 16'sd0);
    send_point(16'sd32767, 16'sd0);
    send_point(16'sd0, 16'sd32767);
    send_point(-16'sd32768, 16'sd0);     // zero denominator, x nonzero
    send_point(16'sd0, -16'sd32768);     // zero over zero
    send_point(-16'sd32768, -16'sd32768);
    send_point(16'sd32767, 16'sd32767);
    send_point(16'sd23170, 16'sd23170);
    send_point(16'sd23171, 16'sd23171);
    send_point(-16'sd23170, 16'sd23170);
    send_point(16'sd1, 16'sd0);
    send_point(-16'sd1, -16'sd1);
    send_point(16'sd0, -16'sd32767);
    send_point(-16'sd32767, 16'sd0);
    send_point(16'sd0, 16'sd1);
    send_point(16'sd32767, -16'sd1);
    send_point(-16'sd32768, 16'sd1);
    send_point(16'sd1, -16'sd32768);

    send_random(300);
    idle_in = 74;
    idle_out = 27;
    send_random(320);
    idle_in = 0;
    idle_out = 0;
    send_random(320);

    @(negedge clk);
    coord_ch.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[inverse_hammer_projection] OK");
    end else begin
      $display("[inverse_hammer_projection] ERROR");
    end
    $finish;
  end
endmodule
